### rtl/i2crm_pkg.sv
// Package with the shared types, codes and sizes of the I2C register master.
`timescale 1ns / 1ps
package i2crm_pkg;

  // Write buffer size and the width of an index into it.
  localparam int unsigned MAX_LEN = 16;
  localparam int unsigned BUF_AW  = $clog2(MAX_LEN);
  localparam logic [4:0]  MAX_LEN_L = 5'(MAX_LEN);

  // Number of SCL pulses that a bus recovery gives at most.
  localparam logic [3:0] RECOVER_PULSES = 4'd9;

  // Command codes carried in the func field.
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_READ    = 3'd1;
  localparam logic [2:0] FUNC_WRITE   = 3'd2;
  localparam logic [2:0] FUNC_RECOVER = 3'd3;
  localparam logic [2:0] FUNC_LOAD    = 3'd4;

  // Completion status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDR_NAK = 2'd1;
  localparam logic [1:0] ST_REG_NAK  = 2'd2;
  localparam logic [1:0] ST_DATA_NAK = 2'd3;

  // Transaction stage: device address, register, read address, data.
  localparam logic [1:0] STG_ADDR  = 2'd0;
  localparam logic [1:0] STG_REG   = 2'd1;
  localparam logic [1:0] STG_RADDR = 2'd2;
  localparam logic [1:0] STG_DATA  = 2'd3;

  // Bus sequencer phases; each one holds a line level for one half period.
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_S_SDA_H  = 5'd1,
    PH_S_SCL_H  = 5'd2,
    PH_S_SDA_L  = 5'd3,
    PH_S_SCL_L  = 5'd4,
    PH_W_DATA   = 5'd5,
    PH_W_SCL_H  = 5'd6,
    PH_W_SCL_L  = 5'd7,
    PH_A_SDA_H  = 5'd8,
    PH_A_SCL_H  = 5'd9,
    PH_A_SCL_L  = 5'd10,
    PH_R_SDA_H  = 5'd11,
    PH_R_SCL_H  = 5'd12,
    PH_R_SCL_L  = 5'd13,
    PH_R_ACK    = 5'd14,
    PH_R_ACK_H  = 5'd15,
    PH_R_ACK_L  = 5'd16,
    PH_R_REL    = 5'd17,
    PH_P_SDA_L  = 5'd18,
    PH_P_SCL_H  = 5'd19,
    PH_P_SDA_H  = 5'd20,
    PH_V_REL    = 5'd21,
    PH_V_SCL_L  = 5'd22,
    PH_V_SCL_H  = 5'd23,
    PH_V_SDA_L  = 5'd24,
    PH_V_SCL_H2 = 5'd25,
    PH_V_SDA_H  = 5'd26
  } phase_t;

endpackage

### rtl/i2crm_cmd_if.sv
// Channel interfaces of the I2C register master: commands, results, configuration.
`timescale 1ns / 1ps
interface i2crm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic [4:0] length;
  logic [7:0] data_byte;
  logic [3:0] data_index;
  logic       sda_in;
  logic       scl_in;

  modport source (output valid, func, dev_addr, reg_addr, length, data_byte, data_index,
                  sda_in, scl_in, input ready);
  modport sink (input valid, func, dev_addr, reg_addr, length, data_byte, data_index,
                sda_in, scl_in, output ready);
endinterface

interface i2crm_rsp_if;
  logic        valid;
  logic        ready;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        read_valid;
  logic [7:0]  read_data;
  logic        read_last;
  logic        done_res;
  logic [1:0]  status;
  logic        bus_idle;
  logic [31:0] nack_count;
  logic [31:0] recover_count;

  modport source (output valid, scl_out, sda_out, busy_res, read_valid, read_data, read_last,
                  done_res, status, bus_idle, nack_count, recover_count, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, read_valid, read_data, read_last,
                done_res, status, bus_idle, nack_count, recover_count, output ready);
endinterface

interface i2crm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/i2c_register_master_unit.sv
// Top level of the I2C register master: bus sequencer, write buffer and result register.
`timescale 1ns / 1ps
// Channel | Role   | Payload
// --------+--------+--------------------------------------------------------------
// cmd     | sink   | func, dev_addr, reg_addr, length, data_byte, data_index, lines
// rsp     | source | line drives, busy, read byte, completion, status, totals
// cfg     | sink   | half_period_us write data (zero stores one)
//
// Each command transfer yields exactly one result transfer, registered in the following cycle.
// A new command is taken every cycle while the result register is empty or being drained.
// The result register is the only stall point; cmd.ready drops only while rsp is stalled or rst is high.
// Reset (rst, synchronous) releases both lines, returns to idle and clears the totals.
// The write buffer has no reset; entries are defined once loaded.
module i2c_register_master_unit
  import i2crm_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  i2crm_cmd_if.sink      cmd,
  i2crm_rsp_if.source    rsp,
  i2crm_cfg_if.sink      cfg
);

  // Sequencer state.
  phase_t      phase, phase_next;
  logic [7:0]  tick_left, tick_left_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [4:0]  byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [6:0]  latched_device, latched_device_next;
  logic [7:0]  latched_register, latched_register_next;
  logic [4:0]  latched_length, latched_length_next;
  logic [3:0]  pulse_count, pulse_count_next;
  logic        scl_drive, scl_drive_next;
  logic        sda_drive, sda_drive_next;
  logic [31:0] nack_total, nack_total_next;
  logic [31:0] recover_total, recover_total_next;
  logic [1:0]  stage, stage_next;
  logic        op_read, op_read_next;
  logic [1:0]  pending_status, pending_status_next;
  logic [7:0]  half_period;

  logic [7:0]  write_buffer [MAX_LEN];

  // Result register.
  logic        rsp_valid;
  logic        res_read_valid, res_read_last, res_done, res_bus_idle;
  logic [7:0]  res_read_data;
  logic [1:0]  res_status;

  // Per-item results and control of the combinational step.
  logic        rv, rl, done, idle;
  logic [7:0]  rd;
  logic [1:0]  st;
  logic        go_en, write_next, buf_we;
  phase_t      go_ph;
  logic        cmd_xfer;

  assign cmd.ready = !rst && (!rsp_valid || rsp.ready);
  assign cfg.ready = !rst;
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign buf_we    = cmd_xfer && (phase == PH_IDLE) && (cmd.func == FUNC_LOAD)
                     && ({1'b0, cmd.data_index} < 5'(MAX_LEN));

  // One sequencer step for the incoming item.
  always_comb begin
    phase_next            = phase;
    tick_left_next        = tick_left;
    bit_count_next        = bit_count;
    byte_index_next       = byte_index;
    shift_byte_next       = shift_byte;
    latched_device_next   = latched_device;
    latched_register_next = latched_register;
    latched_length_next   = latched_length;
    pulse_count_next      = pulse_count;
    scl_drive_next        = scl_drive;
    sda_drive_next        = sda_drive;
    nack_total_next       = nack_total;
    recover_total_next    = recover_total;
    stage_next            = stage;
    op_read_next          = op_read;
    pending_status_next   = pending_status;
    rv         = 1'b0;
    rd         = 8'd0;
    rl         = 1'b0;
    done       = 1'b0;
    st         = ST_OK;
    idle       = 1'b0;
    go_en      = 1'b0;
    go_ph      = PH_IDLE;
    write_next = 1'b0;

    if (cmd.func == FUNC_TICK) begin
      if (phase != PH_IDLE) begin
        if (tick_left > 8'd1) begin
          tick_left_next = tick_left - 8'd1;
        end else begin
          case (phase)
            PH_S_SCL_L: begin
              shift_byte_next = {latched_device, (stage == STG_RADDR)};
              bit_count_next  = 4'd0;
              go_en = 1'b1; go_ph = PH_W_DATA;
            end
            PH_W_SCL_L: begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
              bit_count_next  = bit_count + 4'd1;
              go_en = 1'b1;
              go_ph = (bit_count_next < 4'd8) ? PH_W_DATA : PH_A_SDA_H;
            end
            PH_A_SCL_H: begin
              shift_byte_next = {7'd0, cmd.sda_in};
              go_en = 1'b1; go_ph = PH_A_SCL_L;
            end
            PH_A_SCL_L: begin
              // Acknowledge bit decides whether the transfer goes on.
              if (shift_byte[0]) begin
                nack_total_next = nack_total + 32'd1;
                pending_status_next = (stage == STG_ADDR) ? ST_ADDR_NAK :
                                      (stage == STG_REG) ? ST_REG_NAK : ST_DATA_NAK;
                go_en = 1'b1; go_ph = PH_P_SDA_L;
              end else if (stage == STG_ADDR) begin
                stage_next      = STG_REG;
                shift_byte_next = latched_register;
                bit_count_next  = 4'd0;
                go_en = 1'b1; go_ph = PH_W_DATA;
              end else if (stage == STG_REG) begin
                stage_next = STG_RADDR;
                if (op_read) begin
                  go_en = 1'b1; go_ph = PH_S_SDA_H;
                end else begin
                  write_next = 1'b1;
                end
              end else if (op_read) begin
                stage_next = STG_DATA;
                if (latched_length != 5'd0) begin
                  shift_byte_next = 8'd0;
                  bit_count_next  = 4'd0;
                  go_en = 1'b1; go_ph = PH_R_SDA_H;
                end else begin
                  pending_status_next = ST_OK;
                  go_en = 1'b1; go_ph = PH_P_SDA_L;
                end
              end else begin
                byte_index_next = byte_index + 5'd1;
                write_next = 1'b1;
              end
            end
            PH_R_SCL_H: begin
              shift_byte_next = {shift_byte[6:0], cmd.sda_in};
              go_en = 1'b1; go_ph = PH_R_SCL_L;
            end
            PH_R_SCL_L: begin
              bit_count_next = bit_count + 4'd1;
              go_en = 1'b1;
              go_ph = (bit_count_next < 4'd8) ? PH_R_SCL_H : PH_R_ACK;
            end
            PH_R_REL: begin
              rv = 1'b1;
              rd = shift_byte;
              rl = ({1'b0, byte_index} + 6'd1) == {1'b0, latched_length};
              byte_index_next = byte_index + 5'd1;
              if (byte_index_next < latched_length) begin
                shift_byte_next = 8'd0;
                bit_count_next  = 4'd0;
                go_en = 1'b1; go_ph = PH_R_SDA_H;
              end else begin
                pending_status_next = ST_OK;
                go_en = 1'b1; go_ph = PH_P_SDA_L;
              end
            end
            PH_P_SDA_H: begin
              done = 1'b1;
              st   = pending_status;
              phase_next = PH_IDLE;
            end
            PH_V_REL: begin
              if (!cmd.sda_in) begin
                pulse_count_next = 4'd0;
                go_en = 1'b1; go_ph = PH_V_SCL_L;
              end else begin
                done = 1'b1;
                idle = cmd.sda_in && cmd.scl_in;
                phase_next = PH_IDLE;
              end
            end
            PH_V_SCL_H: begin
              pulse_count_next = pulse_count + 4'd1;
              go_en = 1'b1;
              go_ph = (cmd.sda_in || pulse_count_next >= RECOVER_PULSES) ? PH_V_SDA_L
                                                                         : PH_V_SCL_L;
            end
            PH_V_SDA_H: begin
              done = 1'b1;
              idle = cmd.sda_in && cmd.scl_in;
              phase_next = PH_IDLE;
            end
            default: begin
              go_en = 1'b1;
              go_ph = phase_t'(phase + 5'd1);
            end
          endcase
        end
      end
    end else if (phase == PH_IDLE) begin
      case (cmd.func)
        FUNC_RECOVER: begin
          recover_total_next = recover_total + 32'd1;
          go_en = 1'b1; go_ph = PH_V_REL;
        end
        FUNC_READ, FUNC_WRITE: begin
          latched_device_next   = cmd.dev_addr;
          latched_register_next = cmd.reg_addr;
          latched_length_next   = (cmd.length > MAX_LEN_L) ? MAX_LEN_L : cmd.length;
          op_read_next          = (cmd.func == FUNC_READ);
          stage_next            = STG_ADDR;
          byte_index_next       = 5'd0;
          pending_status_next   = ST_OK;
          go_en = 1'b1; go_ph = PH_S_SDA_H;
        end
        default: begin
        end
      endcase
    end

    // Next write data byte from the buffer, or STOP when all are sent.
    if (write_next) begin
      if (byte_index_next < latched_length && byte_index_next < MAX_LEN_L) begin
        shift_byte_next = write_buffer[byte_index_next[BUF_AW-1:0]];
        bit_count_next  = 4'd0;
        go_en = 1'b1; go_ph = PH_W_DATA;
      end else begin
        pending_status_next = ST_OK;
        go_en = 1'b1; go_ph = PH_P_SDA_L;
      end
    end

    // Entering a phase sets its line levels and restarts the hold count.
    if (go_en) begin
      phase_next     = go_ph;
      tick_left_next = half_period;
      case (go_ph)
        PH_S_SDA_H, PH_A_SDA_H, PH_R_SDA_H, PH_R_REL, PH_P_SDA_H, PH_V_SDA_H:
          sda_drive_next = 1'b1;
        PH_S_SDA_L, PH_P_SDA_L, PH_V_SDA_L:
          sda_drive_next = 1'b0;
        PH_S_SCL_H, PH_W_SCL_H, PH_A_SCL_H, PH_R_SCL_H, PH_R_ACK_H, PH_P_SCL_H,
        PH_V_SCL_H, PH_V_SCL_H2:
          scl_drive_next = 1'b1;
        PH_S_SCL_L, PH_W_SCL_L, PH_A_SCL_L, PH_R_SCL_L, PH_R_ACK_L, PH_V_SCL_L:
          scl_drive_next = 1'b0;
        PH_W_DATA:
          sda_drive_next = shift_byte_next[7];
        PH_R_ACK:
          sda_drive_next = ({1'b0, byte_index_next} + 6'd1) == {1'b0, latched_length_next};
        PH_V_REL: begin
          scl_drive_next = 1'b1;
          sda_drive_next = 1'b1;
        end
        default: begin
          phase_next     = PH_IDLE;
          tick_left_next = tick_left;
        end
      endcase
    end
  end

  // Sequencer state register, updated on each command transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_left        <= 8'd0;
      bit_count        <= 4'd0;
      byte_index       <= 5'd0;
      shift_byte       <= 8'd0;
      latched_device   <= 7'd0;
      latched_register <= 8'd0;
      latched_length   <= 5'd0;
      pulse_count      <= 4'd0;
      scl_drive        <= 1'b1;
      sda_drive        <= 1'b1;
      nack_total       <= 32'd0;
      recover_total    <= 32'd0;
      stage            <= STG_ADDR;
      op_read          <= 1'b0;
      pending_status   <= ST_OK;
    end else if (cmd_xfer) begin
      phase            <= phase_next;
      tick_left        <= tick_left_next;
      bit_count        <= bit_count_next;
      byte_index       <= byte_index_next;
      shift_byte       <= shift_byte_next;
      latched_device   <= latched_device_next;
      latched_register <= latched_register_next;
      latched_length   <= latched_length_next;
      pulse_count      <= pulse_count_next;
      scl_drive        <= scl_drive_next;
      sda_drive        <= sda_drive_next;
      nack_total       <= nack_total_next;
      recover_total    <= recover_total_next;
      stage            <= stage_next;
      op_read          <= op_read_next;
      pending_status   <= pending_status_next;
    end
  end

  // Half period register; a zero write stores one.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= 8'd4;
    end else if (cfg.valid && cfg.ready) begin
      half_period <= (cfg.data == 8'd0) ? 8'd1 : cfg.data;
    end
  end

  // Write data buffer, loaded by load commands while idle.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      write_buffer[cmd.data_index[BUF_AW-1:0]] <= cmd.data_byte;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd_xfer) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result payload, captured with each command transfer.
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      res_read_valid <= rv;
      res_read_data  <= rd;
      res_read_last  <= rl;
      res_done       <= done;
      res_status     <= st;
      res_bus_idle   <= idle;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.scl_out       = scl_drive;
  assign rsp.sda_out       = sda_drive;
  assign rsp.busy_res      = (phase != PH_IDLE);
  assign rsp.read_valid    = res_read_valid;
  assign rsp.read_data     = res_read_data;
  assign rsp.read_last     = res_read_last;
  assign rsp.done_res      = res_done;
  assign rsp.status        = res_status;
  assign rsp.bus_idle      = res_bus_idle;
  assign rsp.nack_count    = nack_total;
  assign rsp.recover_count = recover_total;

endmodule

### rtl/i2crm_checker.sv
// Port-level checker of the I2C register master and its bind to the top level.
`timescale 1ns / 1ps
module i2crm_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_busy,
  input logic        rsp_read_valid,
  input logic        rsp_done,
  input logic [7:0]  rsp_read_data,
  input logic [31:0] rsp_nack_count
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                && $stable(rsp_nack_count))
    else $error("stalled result changed");

  // Every command transfer gives a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> rsp_valid)
    else $error("command transfer without a result");

  // Commands are refused only while a result is stalled.
  assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> rsp_valid && !rsp_ready)
    else $error("command channel stalled without cause");

  // A received byte never ends the operation; the bus stays busy.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_read_valid |-> rsp_busy && !rsp_done)
    else $error("read byte with completion or idle sequencer");

  // A finished operation leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_done |-> !rsp_busy)
    else $error("completion while busy");

endmodule

bind i2c_register_master_unit i2crm_checker u_i2crm_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_busy       (rsp.busy_res),
  .rsp_read_valid (rsp.read_valid),
  .rsp_done       (rsp.done_res),
  .rsp_read_data  (rsp.read_data),
  .rsp_nack_count (rsp.nack_count)
);
